### rtl/core/u8c_pkg.sv
// Shared types, constants and the cp1251 high-half table for the UTF-8/cp1251 decoder.
package u8c_pkg;

	// Register map
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [0:0] REG_SOURCE_IS_CP1251 = 1'b0;

	// Byte codes of the recognized sequences
	localparam logic [7:0] BYTE_TERM     = 8'h00;
	localparam logic [7:0] LEAD_D0       = 8'hD0;
	localparam logic [7:0] LEAD_D1       = 8'hD1;
	localparam logic [7:0] LEAD_E2       = 8'hE2;
	localparam logic [7:0] D0_YO_TAIL    = 8'h81;
	localparam logic [7:0] D1_YO_TAIL    = 8'h91;
	localparam logic [7:0] CP_YO_UPPER   = 8'hA8;
	localparam logic [7:0] CP_YO_LOWER   = 8'hB8;
	localparam logic [7:0] E2_MID        = 8'h80;
	localparam logic [7:0] E2_DASH_TAIL  = 8'h94;
	localparam logic [7:0] D0_OFFSET     = 8'd48;
	localparam logic [7:0] D1_OFFSET     = 8'd112;
	localparam logic [15:0] UNIT_HYPHEN  = 16'h002D;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_D0   = 2'd1,
		KIND_D1   = 2'd2,
		KIND_E2   = 2'd3
	} lead_kind_t;

	typedef enum logic [1:0] {
		POS_IDLE   = 2'd0,
		POS_SECOND = 2'd1,
		POS_THIRD  = 2'd2
	} seq_pos_t;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       last_byte;
	} src_word_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        unit_valid;
		logic        end_of_string;
	} dst_word_t;

	// Decode result handed to the output stage
	typedef struct packed {
		logic      emit;
		dst_word_t word;
	} dec_result_t;

	localparam logic [15:0] HIGH_HALF [128] = '{
		16'h0402,16'h0403,16'h201A,16'h0453,16'h201E,16'h2026,16'h2020,16'h2021,
		16'h20AC,16'h2030,16'h0409,16'h2039,16'h040A,16'h040C,16'h040B,16'h040F,
		16'h0452,16'h2018,16'h2019,16'h201C,16'h201D,16'h2022,16'h2013,16'h2014,
		16'h0020,16'h2122,16'h0459,16'h203A,16'h045A,16'h045C,16'h045B,16'h045F,
		16'h00A0,16'h040E,16'h045E,16'h0408,16'h00A4,16'h0490,16'h00A6,16'h00A7,
		16'h0401,16'h00A9,16'h0404,16'h00AB,16'h00AC,16'h00AD,16'h00AE,16'h0407,
		16'h00B0,16'h00B1,16'h0406,16'h0456,16'h0491,16'h00B5,16'h00B6,16'h00B7,
		16'h0451,16'h2116,16'h0454,16'h00BB,16'h0458,16'h0405,16'h0455,16'h0457,
		16'h0410,16'h0411,16'h0412,16'h0413,16'h0414,16'h0415,16'h0416,16'h0417,
		16'h0418,16'h0419,16'h041A,16'h041B,16'h041C,16'h041D,16'h041E,16'h041F,
		16'h0420,16'h0421,16'h0422,16'h0423,16'h0424,16'h0425,16'h0426,16'h0427,
		16'h0428,16'h0429,16'h042A,16'h042B,16'h042C,16'h042D,16'h042E,16'h042F,
		16'h0430,16'h0431,16'h0432,16'h0433,16'h0434,16'h0435,16'h0436,16'h0437,
		16'h0438,16'h0439,16'h043A,16'h043B,16'h043C,16'h043D,16'h043E,16'h043F,
		16'h0440,16'h0441,16'h0442,16'h0443,16'h0444,16'h0445,16'h0446,16'h0447,
		16'h0448,16'h0449,16'h044A,16'h044B,16'h044C,16'h044D,16'h044E,16'h044F
	};

	// Widen a cp1251 byte to a UTF-16 unit
	function automatic logic [15:0] widen(input logic [7:0] b);
		logic [15:0] u;
		if (b[7]) begin
			u = HIGH_HALF[b[6:0]];
		end else begin
			u = {8'h00, b};
		end
		return u;
	endfunction

endpackage

### rtl/core/u8c_cfg_regs.sv
// Configuration register file on an APB-style port.
module u8c_cfg_regs
	import u8c_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic                  source_is_cp1251
);

	logic       wr_en;
	logic       hit;
	logic       mode_q;

	assign pready = 1'b1;
	assign hit    = (paddr[CFG_ADDR_W-1:2] == REG_SOURCE_IS_CP1251);
	assign wr_en  = psel && penable && pwrite && pready;

	// Write the mode bit; other addresses are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (wr_en && hit) begin
			mode_q <= pwdata[0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(CFG_DATA_W-1){1'b0}}, mode_q};
		end
	end

	assign source_is_cp1251 = mode_q;

endmodule

### rtl/core/u8c_decode.sv
// Sequence state and per-word decode from the input register to a result.
module u8c_decode
	import u8c_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  src_word_t   word,
	input  logic        source_is_cp1251,
	output dec_result_t result
);

	logic [2:0]  skip_q, skip_d;
	lead_kind_t  kind_q, kind_d;
	seq_pos_t    pos_q, pos_d;
	logic        matched_q, matched_d;
	logic        ended_q, ended_d;

	logic [7:0]  b;
	logic [7:0]  mapped;
	logic [7:0]  wide_in;
	logic [2:0]  lead_skip;
	logic        have;
	logic        use_hyphen;
	logic [15:0] unit;

	assign b = word.source_byte;

	// Second byte of a two-byte Cyrillic pair mapped to cp1251
	always_comb begin
		if (kind_q == KIND_D0) begin
			mapped = (b == D0_YO_TAIL) ? CP_YO_UPPER : b + D0_OFFSET;
		end else begin
			mapped = (b == D1_YO_TAIL) ? CP_YO_LOWER : b + D1_OFFSET;
		end
	end

	// Remaining bytes of an unsupported sequence: leading ones minus one
	always_comb begin
		unique casez (b)
			8'b10??????: lead_skip = 3'd0;
			8'b110?????: lead_skip = 3'd1;
			8'b1110????: lead_skip = 3'd2;
			8'b11110???: lead_skip = 3'd3;
			8'b111110??: lead_skip = 3'd4;
			8'b1111110?: lead_skip = 3'd5;
			8'b11111110: lead_skip = 3'd6;
			8'b11111111: lead_skip = 3'd7;
			default:     lead_skip = 3'd0;
		endcase
	end

	// Next state and unit
	always_comb begin
		skip_d     = skip_q;
		kind_d     = kind_q;
		pos_d      = pos_q;
		matched_d  = matched_q;
		ended_d    = ended_q;
		have       = 1'b0;
		use_hyphen = 1'b0;
		wide_in    = b;
		if (!ended_q) begin
			if (b == BYTE_TERM) begin
				ended_d = 1'b1;
				skip_d  = '0;
				kind_d  = KIND_NONE;
				pos_d   = POS_IDLE;
				matched_d = 1'b0;
			end else if (source_is_cp1251) begin
				skip_d  = '0;
				kind_d  = KIND_NONE;
				pos_d   = POS_IDLE;
				matched_d = 1'b0;
				have    = 1'b1;
			end else if (kind_q == KIND_D0 || kind_q == KIND_D1) begin
				skip_d  = '0;
				kind_d  = KIND_NONE;
				pos_d   = POS_IDLE;
				matched_d = 1'b0;
				wide_in = mapped;
				if (mapped == BYTE_TERM) begin
					ended_d = 1'b1;
				end else begin
					have = 1'b1;
				end
			end else if (kind_q == KIND_E2) begin
				if (pos_q == POS_SECOND) begin
					matched_d = (b == E2_MID);
					pos_d     = POS_THIRD;
				end else begin
					if (matched_q && b == E2_DASH_TAIL) begin
						have       = 1'b1;
						use_hyphen = 1'b1;
					end
					skip_d  = '0;
					kind_d  = KIND_NONE;
					pos_d   = POS_IDLE;
					matched_d = 1'b0;
				end
			end else if (skip_q != 3'd0) begin
				skip_d = skip_q - 3'd1;
			end else if (!b[7]) begin
				have = 1'b1;
			end else if (b == LEAD_D0) begin
				kind_d = KIND_D0;
				pos_d  = POS_SECOND;
			end else if (b == LEAD_D1) begin
				kind_d = KIND_D1;
				pos_d  = POS_SECOND;
			end else if (b == LEAD_E2) begin
				kind_d    = KIND_E2;
				pos_d     = POS_SECOND;
				matched_d = 1'b0;
			end else begin
				skip_d = lead_skip;
			end
		end
		// Last word closes the string and clears everything
		if (word.last_byte) begin
			skip_d    = '0;
			kind_d    = KIND_NONE;
			pos_d     = POS_IDLE;
			matched_d = 1'b0;
			ended_d   = 1'b0;
		end
	end

	assign unit = use_hyphen ? UNIT_HYPHEN : widen(wide_in);

	always_comb begin
		result.emit               = have || word.last_byte;
		result.word.code_unit     = have ? unit : 16'h0000;
		result.word.unit_valid    = have;
		result.word.end_of_string = word.last_byte;
	end

	// Advance state on each consumed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q    <= '0;
			kind_q    <= KIND_NONE;
			pos_q     <= POS_IDLE;
			matched_q <= 1'b0;
			ended_q   <= 1'b0;
		end else if (fire) begin
			skip_q    <= skip_d;
			kind_q    <= kind_d;
			pos_q     <= pos_d;
			matched_q <= matched_d;
			ended_q   <= ended_d;
		end
	end

	// A terminated string holds no open sequence
	a_ended_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> (kind_q == KIND_NONE && skip_q == 3'd0 && pos_q == POS_IDLE))
		else $error("open sequence after terminator");

	// A skip count never coexists with an open lead
	a_skip_no_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(skip_q != 3'd0) |-> (kind_q == KIND_NONE))
		else $error("skip count with open lead");

endmodule

### rtl/core/u8c_out_stage.sv
// Result register toward the downstream channel.
module u8c_out_stage
	import u8c_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  dst_word_t   load_word,
	input  logic        dst_stall,
	output logic        free,
	output logic        dst_valid,
	output dst_word_t   dst_word
);

	logic      valid_s2;
	dst_word_t word_s2;

	assign free = !valid_s2 || !dst_stall;

	// Take a new result when the register is empty or empties this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			word_s2 <= load_word;
		end
	end

	assign dst_valid = valid_s2;
	assign dst_word  = word_s2;

endmodule

### rtl/core/utf8_cp1251_to_utf16_decoder.sv
// Top level: UTF-8 subset or cp1251 byte stream to UTF-16 code units.
// The decoder takes one byte per clock and sustains one byte per cycle with
// no bubbles while downstream does not stall. Each byte passes an input
// register, then combinational decode (sequence state update and one
// 128-entry table read) into the result register, which offers the result
// downstream. A byte yields a result only when it produces a unit or carries
// last_byte; bytes that only open or continue a sequence produce nothing.
// Downstream stall backs up through the result register into src_stall in
// the same cycle.
// Mode (source_is_cp1251) is set over the APB port at address 0 and should
// be changed only while the decoder is idle.
module utf8_cp1251_to_utf16_decoder
	import u8c_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  src_word_t             src_word,
	output logic                  dst_valid,
	input  logic                  dst_stall,
	output dst_word_t             dst_word,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic        source_is_cp1251;
	logic        valid_s1;
	src_word_t   word_s1;
	logic        out_free;
	logic        fire_s1;
	logic        accept;
	dec_result_t result;

	u8c_cfg_regs u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.source_is_cp1251 (source_is_cp1251)
	);

	assign fire_s1   = valid_s1 && out_free;
	assign src_stall = valid_s1 && !out_free;
	assign accept    = src_valid && !src_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= src_word;
		end
	end

	u8c_decode u_decode (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (fire_s1),
		.word             (word_s1),
		.source_is_cp1251 (source_is_cp1251),
		.result           (result)
	);

	u8c_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire_s1 && result.emit),
		.load_word (result.word),
		.dst_stall (dst_stall),
		.free      (out_free),
		.dst_valid (dst_valid),
		.dst_word  (dst_word)
	);

	// The last byte of a string always yields a closing result
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && word_s1.last_byte) |=> (dst_valid && dst_word.end_of_string))
		else $error("last byte gave no end-of-string result");

	// An empty result only closes a string, and carries a zero unit
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && !dst_word.unit_valid) |->
			(dst_word.end_of_string && dst_word.code_unit == 16'h0000))
		else $error("empty result not at end of string");

	// Input stalls only behind a full input register, a full result register and a downstream stall
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (valid_s1 && dst_valid && dst_stall))
		else $error("input stalled with room downstream");

endmodule

### tb/utf8_cp1251_to_utf16_decoder_tb.sv
// Self-checking testbench for the UTF-8/cp1251 to UTF-16 decoder.
`timescale 1ns / 1ps

module utf8_cp1251_to_utf16_decoder_tb
	import u8c_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned PIPE_DEPTH = 2;
	localparam int unsigned PHASE_ITEMS = 60;
	localparam logic [CFG_ADDR_W-1:0] MODE_ADDR = CFG_ADDR_W'(4 * REG_SOURCE_IS_CP1251);
	localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = CFG_ADDR_W'(4);

	// cp1251 bytes 0x80..0xFF widened to UTF-16
	localparam logic [15:0] CP1251_HIGH [128] = '{
		16'h0402,16'h0403,16'h201A,16'h0453,16'h201E,16'h2026,16'h2020,16'h2021,
		16'h20AC,16'h2030,16'h0409,16'h2039,16'h040A,16'h040C,16'h040B,16'h040F,
		16'h0452,16'h2018,16'h2019,16'h201C,16'h201D,16'h2022,16'h2013,16'h2014,
		16'h0020,16'h2122,16'h0459,16'h203A,16'h045A,16'h045C,16'h045B,16'h045F,
		16'h00A0,16'h040E,16'h045E,16'h0408,16'h00A4,16'h0490,16'h00A6,16'h00A7,
		16'h0401,16'h00A9,16'h0404,16'h00AB,16'h00AC,16'h00AD,16'h00AE,16'h0407,
		16'h00B0,16'h00B1,16'h0406,16'h0456,16'h0491,16'h00B5,16'h00B6,16'h00B7,
		16'h0451,16'h2116,16'h0454,16'h00BB,16'h0458,16'h0405,16'h0455,16'h0457,
		16'h0410,16'h0411,16'h0412,16'h0413,16'h0414,16'h0415,16'h0416,16'h0417,
		16'h0418,16'h0419,16'h041A,16'h041B,16'h041C,16'h041D,16'h041E,16'h041F,
		16'h0420,16'h0421,16'h0422,16'h0423,16'h0424,16'h0425,16'h0426,16'h0427,
		16'h0428,16'h0429,16'h042A,16'h042B,16'h042C,16'h042D,16'h042E,16'h042F,
		16'h0430,16'h0431,16'h0432,16'h0433,16'h0434,16'h0435,16'h0436,16'h0437,
		16'h0438,16'h0439,16'h043A,16'h043B,16'h043C,16'h043D,16'h043E,16'h043F,
		16'h0440,16'h0441,16'h0442,16'h0443,16'h0444,16'h0445,16'h0446,16'h0447,
		16'h0448,16'h0449,16'h044A,16'h044B,16'h044C,16'h044D,16'h044E,16'h044F
	};

	typedef struct packed {
		logic       mode;
		logic [7:0] data;
		logic       last;
		logic       typed;
		dst_word_t  unit;
	} stim_row_t;

	localparam dst_word_t NO_UNIT = '0;

	// Directed strings; typed rows carry their unit, the rest go through the predictor
	localparam stim_row_t DIRECTED_ROWS [27] = '{
		'{1'b0, BYTE_TERM, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}},
		'{1'b0, 8'h7F,     1'b0, 1'b1, '{16'h007F, 1'b1, 1'b0}},
		'{1'b0, LEAD_D0,   1'b0, 1'b0, NO_UNIT},
		'{1'b0, 8'h81,     1'b0, 1'b1, '{16'h0401, 1'b1, 1'b0}},
		'{1'b0, LEAD_D1,   1'b0, 1'b0, NO_UNIT},
		'{1'b0, 8'h91,     1'b0, 1'b1, '{16'h0451, 1'b1, 1'b0}},
		'{1'b0, LEAD_D0,   1'b0, 1'b0, NO_UNIT},
		'{1'b0, 8'h90,     1'b0, 1'b0, NO_UNIT},
		'{1'b0, LEAD_E2,   1'b0, 1'b0, NO_UNIT},
		'{1'b0, 8'h80,     1'b0, 1'b0, NO_UNIT},
		'{1'b0, 8'h94,     1'b0, 1'b1, '{16'h002D, 1'b1, 1'b0}},
		'{1'b0, LEAD_E2,   1'b0, 1'b0, NO_UNIT},
		'{1'b0, 8'h81,     1'b0, 1'b0, NO_UNIT},
		'{1'b0, 8'h94,     1'b0, 1'b0, NO_UNIT},
		'{1'b0, 8'hC3,     1'b0, 1'b0, NO_UNIT},
		'{1'b0, 8'hA9,     1'b0, 1'b0, NO_UNIT},
		'{1'b0, LEAD_D1,   1'b0, 1'b0, NO_UNIT},
		'{1'b0, 8'h90,     1'b0, 1'b0, NO_UNIT},
		'{1'b0, 8'h41,     1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}},
		'{1'b0, LEAD_E2,   1'b0, 1'b0, NO_UNIT},
		'{1'b0, BYTE_TERM, 1'b0, 1'b0, NO_UNIT},
		'{1'b0, 8'h41,     1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}},
		'{1'b0, LEAD_D0,   1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}},
		'{1'b0, LEAD_D1,   1'b0, 1'b0, NO_UNIT},
		'{1'b1, 8'hFF,     1'b0, 1'b0, NO_UNIT},
		'{1'b1, 8'h80,     1'b0, 1'b1, '{16'h0402, 1'b1, 1'b0}},
		'{1'b1, 8'h01,     1'b1, 1'b1, '{16'h0001, 1'b1, 1'b1}}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  src_valid = 1'b0;
	logic                  src_stall;
	src_word_t             src_word = '0;
	logic                  dst_valid;
	logic                  dst_stall = 1'b1;
	dst_word_t             dst_word;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// Predictor state
	logic       cp_mode = 1'b0;
	logic [2:0] skip_left = '0;
	lead_kind_t lead = KIND_NONE;
	seq_pos_t   seq_pos = POS_IDLE;
	logic       mid_matched = 1'b0;
	logic       ended = 1'b0;

	dst_word_t pending_units[$];
	dst_word_t oldest_unit;
	int src_idle_pct = 22;
	int dst_idle_pct = 87;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned units_seen = 0;
	int unsigned mode_writes = 0;
	int unsigned mismatches = 0;

	utf8_cp1251_to_utf16_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_word(src_word),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_word(dst_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Random receiver backpressure
	always @(posedge clk) begin
		dst_stall <= ($urandom_range(99) < dst_idle_pct);
	end

	function automatic int count_leading_ones(input logic [7:0] b);
		int n;
		n = 0;
		while (n < 8 && b[7 - n])
			n++;
		return n;
	endfunction

	function automatic logic [15:0] cp1251_unit(input logic [7:0] b);
		return b[7] ? CP1251_HIGH[b[6:0]] : {8'h00, b};
	endfunction

	function automatic void drop_sequence();
		skip_left = '0;
		lead = KIND_NONE;
		seq_pos = POS_IDLE;
		mid_matched = 1'b0;
	endfunction

	// Advance the decoder state by one byte and form the word it should emit
	function automatic void decode_byte(input logic [7:0] b, input logic l,
			output logic produced, output dst_word_t w);
		logic        have;
		logic [15:0] unit;
		logic [7:0]  mapped;
		have = 1'b0;
		unit = '0;
		mapped = '0;
		if (!ended) begin
			if (b == BYTE_TERM) begin
				ended = 1'b1;
				drop_sequence();
			end else if (cp_mode) begin
				drop_sequence();
				have = 1'b1;
				unit = cp1251_unit(b);
			end else if (lead == KIND_D0 || lead == KIND_D1) begin
				if (lead == KIND_D0) begin
					mapped = (b == D0_YO_TAIL) ? CP_YO_UPPER : b + D0_OFFSET;
				end else begin
					mapped = (b == D1_YO_TAIL) ? CP_YO_LOWER : b + D1_OFFSET;
				end
				drop_sequence();
				// a pair that maps to zero terminates like a zero byte
				if (mapped == BYTE_TERM) begin
					ended = 1'b1;
				end else begin
					have = 1'b1;
					unit = cp1251_unit(mapped);
				end
			end else if (lead == KIND_E2) begin
				if (seq_pos == POS_SECOND) begin
					mid_matched = (b == E2_MID);
					seq_pos = POS_THIRD;
				end else begin
					if (mid_matched && b == E2_DASH_TAIL) begin
						have = 1'b1;
						unit = UNIT_HYPHEN;
					end
					drop_sequence();
				end
			end else if (skip_left != 3'd0) begin
				skip_left = skip_left - 3'd1;
			end else if (!b[7]) begin
				have = 1'b1;
				unit = {8'h00, b};
			end else if (b == LEAD_D0) begin
				lead = KIND_D0;
				seq_pos = POS_SECOND;
			end else if (b == LEAD_D1) begin
				lead = KIND_D1;
				seq_pos = POS_SECOND;
			end else if (b == LEAD_E2) begin
				lead = KIND_E2;
				seq_pos = POS_SECOND;
				mid_matched = 1'b0;
			end else begin
				skip_left = 3'(count_leading_ones(b) - 1);
			end
		end
		produced = have || l;
		w.code_unit = have ? unit : 16'h0000;
		w.unit_valid = have;
		w.end_of_string = l;
		if (l) begin
			ended = 1'b0;
			drop_sequence();
		end
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endtask

	// Compare each accepted word with the oldest expected unit
	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			units_seen++;
			if (pending_units.size() == 0) begin
				$error("unexpected word: code_unit %h unit_valid %b end_of_string %b",
					dst_word.code_unit, dst_word.unit_valid, dst_word.end_of_string);
				mismatches++;
			end else begin
				oldest_unit = pending_units.pop_front();
				check_field("code_unit", oldest_unit.code_unit, dst_word.code_unit);
				check_field("unit_valid", 16'(oldest_unit.unit_valid),
					16'(dst_word.unit_valid));
				check_field("end_of_string", 16'(oldest_unit.end_of_string),
					16'(dst_word.end_of_string));
			end
		end
	end

	// Offer one byte, hold it until accepted, then record its expected unit if it yields one
	task automatic push_word(input logic [7:0] b, input logic l, input logic typed,
			input dst_word_t typed_unit);
		logic      produced;
		dst_word_t unit;
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_word <= '{source_byte: b, last_byte: l};
		do @(posedge clk); while (src_stall);
		items_sent++;
		decode_byte(b, l, produced, unit);
		if (produced) begin
			pending_units.push_back(typed ? typed_unit : unit);
		end
	endtask

	// Drop valid, wait out every expected unit and the pipeline behind it
	task automatic drain();
		src_valid <= 1'b0;
		while (pending_units.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 3) @(posedge clk);
	endtask

	task automatic apb_write(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (a == MODE_ADDR) begin
			cp_mode = d[0];
		end
	endtask

	task automatic apb_read(input logic [CFG_ADDR_W-1:0] a, output logic [CFG_DATA_W-1:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= a;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		d = prdata;
	endtask

	// Set the mode once idle, poke the unmapped slot and read the mode back
	task automatic configure(input logic new_mode);
		logic [CFG_DATA_W-1:0] rd;
		drain();
		apb_write(MODE_ADDR, {(CFG_DATA_W-1)'($urandom), new_mode});
		apb_write(SPARE_ADDR, CFG_DATA_W'($urandom));
		apb_read(MODE_ADDR, rd);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mode_writes++;
		check_field("source_is_cp1251", 16'(cp_mode), 16'(rd[0]));
	endtask

	// Build a string of mostly well-formed sequences with some noise, maybe cut short
	task automatic send_utf8_string();
		logic [7:0] text[$];
		logic [7:0] lead_b;
		int tokens;
		int pick;
		tokens = $urandom_range(1, 10);
		repeat (tokens) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				text.push_back(8'($urandom_range(1, 127)));
			end else if (pick < 50) begin
				text.push_back($urandom_range(1) ? LEAD_D1 : LEAD_D0);
				case ($urandom_range(5))
					0: text.push_back(D0_YO_TAIL);
					1: text.push_back(D1_YO_TAIL);
					2: text.push_back(8'h90);
					3: text.push_back(8'($urandom_range(255)));
					default: text.push_back(8'($urandom_range(8'h80, 8'hBF)));
				endcase
			end else if (pick < 60) begin
				text.push_back(LEAD_E2);
				text.push_back(E2_MID);
				text.push_back(E2_DASH_TAIL);
			end else if (pick < 68) begin
				text.push_back(LEAD_E2);
				text.push_back($urandom_range(1) ? E2_MID : 8'($urandom_range(255)));
				text.push_back($urandom_range(1) ? E2_DASH_TAIL : 8'($urandom_range(255)));
			end else if (pick < 85) begin
				lead_b = 8'($urandom_range(8'hC0, 8'hFF));
				text.push_back(lead_b);
				repeat (count_leading_ones(lead_b) - 1)
					text.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end else if (pick < 90) begin
				text.push_back(BYTE_TERM);
			end else begin
				text.push_back(8'($urandom_range(255)));
			end
		end
		if (text.size() > 1 && $urandom_range(4) == 0) begin
			void'(text.pop_back());
		end
		foreach (text[i]) begin
			push_word(text[i], i == text.size() - 1, 1'b0, NO_UNIT);
		end
	endtask

	task automatic send_cp1251_string();
		int n;
		n = $urandom_range(1, 12);
		for (int i = 0; i < n; i++) begin
			push_word(($urandom_range(19) == 0) ? BYTE_TERM : 8'($urandom_range(1, 255)),
				i == n - 1, 1'b0, NO_UNIT);
		end
	endtask

	initial begin
		int unsigned target;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings, switching mode where a row asks for it
		for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
			if (DIRECTED_ROWS[r].mode != cp_mode) begin
				configure(DIRECTED_ROWS[r].mode);
			end
			push_word(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].last,
				DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].unit);
		end

		// Random strings over alternating modes and three idle patterns
		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin
					src_idle_pct = 22;
					dst_idle_pct = 87;
				end
				1: begin
					src_idle_pct = 87;
					dst_idle_pct = 22;
				end
				default: begin
					src_idle_pct = 0;
					dst_idle_pct = 0;
				end
			endcase
			configure(ph[0]);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				if (cp_mode) begin
					send_cp1251_string();
				end else begin
					send_utf8_string();
				end
				// hold the sender now and then until the output is empty
				if ($urandom_range(19) == 0) begin
					drain();
				end
			end
		end

		drain();
		$display("Sent %0d bytes in both source modes over %0d mode writes; %0d words checked.",
			items_sent, mode_writes, units_seen);
		$display("Mismatches: %0d", mismatches);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/u8c_pkg.sv
rtl/core/u8c_cfg_regs.sv
rtl/core/u8c_decode.sv
rtl/core/u8c_out_stage.sv
rtl/core/utf8_cp1251_to_utf16_decoder.sv
tb/utf8_cp1251_to_utf16_decoder_tb.sv
